/* rtl/sobel_pkg.sv */
package sobel_pkg;

  // Default sizing of the line stores and the frame
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int IMG_W_BITS = 11;
  localparam int IMG_H_BITS = 13;

  localparam logic [IMG_W_BITS-1:0] RESET_WIDTH  = 11'd640;
  localparam logic [IMG_H_BITS-1:0] RESET_HEIGHT = 13'd480;
  localparam int MIN_WIDTH  = 3;
  localparam int MIN_HEIGHT = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  // Pixel and result fields
  localparam int PIX_W     = 8;
  localparam int ROW_W     = 13;
  localparam int OUT_COL_W = 10;
  localparam int OUT_ROW_W = 12;
  localparam int PIX_MAX   = 255;

  // Gray conversion: floor(x / 3) as (x * 683) >> 11 for x <= 765
  localparam int RGB_SUM_W  = 10;
  localparam int GRAY_RECIP = 683;
  localparam int GRAY_SHIFT = 11;
  localparam int GRAY_PROD_W = 20;

  // Gradient and magnitude
  localparam int GRAD_W    = 11;
  localparam int GSUM_W    = 10;
  localparam int SQ_W      = 20;
  localparam int ROOT_REG_W = 22;
  localparam int ROOT_W    = 11;
  localparam int ROOT_TOP_BIT = 20;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic read;
    logic update;
    logic grad;
    logic square;
    logic sum;
    logic root_step;
    logic emit;
  } sobel_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hit;
    logic root_last;
    logic out_free;
  } sobel_status_t;

endpackage

/* rtl/sobel_edge_detector_core.sv */
// Streaming 3x3 Sobel edge detector.
// Input channel (in_valid/in_ready): one RGB pixel per transaction in raster
// order; op high marks a padding tick that counts as a pixel of gray 0. After
// the last pixel of a frame, send image_width + 1 padding ticks to flush it.
// Output channel (out_valid/out_ready): 255 minus the gradient magnitude,
// clamped at 0, with the column and row it belongs to; frame_end marks the
// last pixel of the frame. A result belongs to the pixel one row plus one
// pixel before the transaction that produces it.
// Steps: a transaction that produces no result passes accept, line store
// read, and line store write with window shift. One that produces a result
// goes on to gradient, square, sum, 11 steps of the shared bit-pair square
// root, and the output load. The root unit and the single line store port
// set this sequence. The output register frees the input side: the next
// pixel is taken while a result waits. A stalled receiver holds the result;
// a next result load then waits, and input with it. Configuration (cfg_we,
// cfg_index, cfg_data) is to be written by the user only while idle; the
// block does not enforce it. Reset clears the position counters and window
// and sets the frame size to 640 x 480; line store contents stay as they are.
module sobel_edge_detector_core
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  op,
  input  logic [PIX_W-1:0]      red,
  input  logic [PIX_W-1:0]      green,
  input  logic [PIX_W-1:0]      blue,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      edge_res,
  output logic [OUT_COL_W-1:0]  out_col,
  output logic [OUT_ROW_W-1:0]  out_row,
  output logic                  frame_end
);

  sobel_cmd_t    cmd;
  sobel_status_t status;

  // Sequencer
  sobel_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Line stores, window, gradient and root
  sobel_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .edge_res  (edge_res),
    .out_col   (out_col),
    .out_row   (out_row),
    .frame_end (frame_end)
  );

endmodule

/* rtl/sobel_ctrl.sv */
module sobel_ctrl
  import sobel_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sobel_status_t status,
  output sobel_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_READ   = 8'b0000_0010,
    S_UPDATE = 8'b0000_0100,
    S_GRAD   = 8'b0000_1000,
    S_SQUARE = 8'b0001_0000,
    S_SUM    = 8'b0010_0000,
    S_ROOT   = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Decode commands and next state; take nothing while in reset
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready    = !rst;
        cmd.capture = in_valid && !rst;
        if (in_valid && !rst) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = status.hit ? S_GRAD : S_IDLE;
      end
      S_GRAD: begin
        cmd.grad   = 1'b1;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = status.out_free;
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/sobel_dp.sv */
module sobel_dp
  import sobel_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sobel_cmd_t            cmd,
  output sobel_status_t         status,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  op,
  input  logic [PIX_W-1:0]      red,
  input  logic [PIX_W-1:0]      green,
  input  logic [PIX_W-1:0]      blue,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [PIX_W-1:0]      edge_res,
  output logic [OUT_COL_W-1:0]  out_col,
  output logic [OUT_ROW_W-1:0]  out_row,
  output logic                  frame_end
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = CW + 1;
  localparam int WCW = (IMG_W_BITS > WW) ? IMG_W_BITS : WW;
  localparam int HCW = (IMG_H_BITS > $clog2(MAX_HEIGHT) + 1) ? IMG_H_BITS
                                                             : $clog2(MAX_HEIGHT) + 1;

  // Configuration registers
  logic [IMG_W_BITS-1:0] image_width;
  logic [IMG_H_BITS-1:0] image_height;

  // Position counters
  logic [CW-1:0]    in_col;
  logic [ROW_W-1:0] in_row;

  // Per-transaction registers
  logic [CW-1:0]    cur_col;
  logic [ROW_W-1:0] tick_row;
  logic [PIX_W-1:0] gray_q;
  logic [PIX_W-1:0] top_q;
  logic [PIX_W-1:0] mid_q;

  // Line stores and window
  logic [PIX_W-1:0] older_line [MAX_WIDTH];
  logic [PIX_W-1:0] newer_line [MAX_WIDTH];
  logic [PIX_W-1:0] win [3][3];

  // Result position and border flags
  logic [CW-1:0]    qc_q;
  logic [ROW_W-1:0] qr_q;
  logic             mask_top;
  logic             mask_bot;
  logic             mask_lft;
  logic             mask_rgt;
  logic             fend_q;

  // Gradient, squares and root
  logic signed [GRAD_W-1:0] vx_q;
  logic signed [GRAD_W-1:0] vy_q;
  logic [SQ_W-1:0]          sq_x;
  logic [SQ_W-1:0]          sq_y;
  logic [ROOT_REG_W-1:0]    rem;
  logic [ROOT_REG_W-1:0]    res;
  logic [ROOT_REG_W-1:0]    rbit;

  // Combinational signals
  logic [WCW-1:0]         w_raw;
  logic [WCW-1:0]         w_full;
  logic [WW-1:0]          w_eff;
  logic [WW-1:0]          w_m1;
  logic [HCW-1:0]         h_raw;
  logic [HCW-1:0]         h_full;
  logic [ROW_W-1:0]       h_eff;
  logic [ROW_W-1:0]       h_m1;
  logic                   wrap;
  logic [RGB_SUM_W-1:0]   rgb_sum;
  logic [GRAY_PROD_W-1:0] gray_prod;
  logic [PIX_W-1:0]       gray_calc;
  logic                   hit;
  logic [CW-1:0]          qc_n;
  logic [ROW_W-1:0]       qr_n;
  logic [WW-1:0]          col_inc;
  logic [PIX_W-1:0]       p [3][3];
  logic [GSUM_W-1:0]      sum_t;
  logic [GSUM_W-1:0]      sum_b;
  logic [GSUM_W-1:0]      sum_l;
  logic [GSUM_W-1:0]      sum_r;
  logic signed [2*GRAD_W-1:0] px;
  logic signed [2*GRAD_W-1:0] py;
  logic [ROOT_REG_W-1:0]  trial;
  logic [ROOT_W-1:0]      mag;
  logic [PIX_W-1:0]       edge_n;

  // Saturate the configured frame size
  always_comb begin
    w_raw = WCW'(image_width);
    if (w_raw < WCW'(MIN_WIDTH)) begin
      w_full = WCW'(MIN_WIDTH);
    end else if (w_raw > WCW'(MAX_WIDTH)) begin
      w_full = WCW'(MAX_WIDTH);
    end else begin
      w_full = w_raw;
    end
    w_eff = WW'(w_full);
    w_m1  = w_eff - WW'(1);

    h_raw = HCW'(image_height);
    if (h_raw < HCW'(MIN_HEIGHT)) begin
      h_full = HCW'(MIN_HEIGHT);
    end else if (h_raw > HCW'(MAX_HEIGHT)) begin
      h_full = HCW'(MAX_HEIGHT);
    end else begin
      h_full = h_raw;
    end
    h_eff = ROW_W'(h_full);
    h_m1  = h_eff - ROW_W'(1);
  end

  // Gray conversion and row close on entry
  always_comb begin
    wrap      = {1'b0, in_col} >= w_eff;
    rgb_sum   = RGB_SUM_W'(red) + RGB_SUM_W'(green) + RGB_SUM_W'(blue);
    gray_prod = GRAY_PROD_W'(rgb_sum) * GRAY_PROD_W'(GRAY_RECIP);
    gray_calc = gray_prod[GRAY_SHIFT +: PIX_W];
  end

  // Result position for the current transaction
  always_comb begin
    hit  = 1'b0;
    qc_n = '0;
    qr_n = '0;
    if (cur_col != '0) begin
      if (tick_row != '0) begin
        hit  = 1'b1;
        qc_n = cur_col - CW'(1);
        qr_n = tick_row - ROW_W'(1);
      end
    end else if (tick_row >= ROW_W'(2)) begin
      hit  = 1'b1;
      qc_n = w_m1[CW-1:0];
      qr_n = tick_row - ROW_W'(2);
    end
    if (qr_n >= h_eff) begin
      hit = 1'b0;
    end
    col_inc = {1'b0, cur_col} + WW'(1);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  image_width  <= cfg_data[IMG_W_BITS-1:0];
        CFG_HEIGHT: image_height <= cfg_data[IMG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Position counters: advance after each transaction, restart past the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col <= '0;
      in_row <= '0;
    end else if (cmd.update) begin
      if ({1'b0, tick_row} >= ({1'b0, h_eff} + (ROW_W + 1)'(1))) begin
        in_col <= '0;
        in_row <= '0;
      end else if (col_inc >= w_eff) begin
        in_col <= '0;
        in_row <= tick_row + ROW_W'(1);
      end else begin
        in_col <= col_inc[CW-1:0];
        in_row <= tick_row;
      end
    end
  end

  // Capture the pixel and its position
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_col  <= wrap ? '0 : in_col;
      tick_row <= wrap ? in_row + ROW_W'(1) : in_row;
      gray_q   <= op ? '0 : gray_calc;
    end
  end

  // Older line store: read, then written back in the following cycle
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      top_q <= older_line[cur_col];
    end
    if (cmd.update) begin
      older_line[cur_col] <= mid_q;
    end
  end

  // Newer line store
  always_ff @(posedge clk) begin
    if (cmd.read) begin
      mid_q <= newer_line[cur_col];
    end
    if (cmd.update) begin
      newer_line[cur_col] <= gray_q;
    end
  end

  // Shift the window by one column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win[r][k] <= '0;
        end
      end
    end else if (cmd.update) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= top_q;
      win[1][2] <= mid_q;
      win[2][2] <= gray_q;
    end
  end

  // Hold the result position and its border flags
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      qc_q     <= qc_n;
      qr_q     <= qr_n;
      mask_top <= qr_n == '0;
      mask_bot <= qr_n == h_m1;
      mask_lft <= qc_n == '0;
      mask_rgt <= qc_n == w_m1[CW-1:0];
      fend_q   <= (qr_n == h_m1) && (qc_n == w_m1[CW-1:0]);
    end
  end

  // Zero the neighbors outside the image
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        if ((r == 0 && mask_top) || (r == 2 && mask_bot) ||
            (k == 0 && mask_lft) || (k == 2 && mask_rgt)) begin
          p[r][k] = '0;
        end else begin
          p[r][k] = win[r][k];
        end
      end
    end
    sum_t = GSUM_W'(p[0][0]) + (GSUM_W'(p[0][1]) << 1) + GSUM_W'(p[0][2]);
    sum_b = GSUM_W'(p[2][0]) + (GSUM_W'(p[2][1]) << 1) + GSUM_W'(p[2][2]);
    sum_r = GSUM_W'(p[0][2]) + (GSUM_W'(p[1][2]) << 1) + GSUM_W'(p[2][2]);
    sum_l = GSUM_W'(p[0][0]) + (GSUM_W'(p[1][0]) << 1) + GSUM_W'(p[2][0]);
  end

  // Gradients, squares and root step
  always_comb begin
    px    = vx_q * vx_q;
    py    = vy_q * vy_q;
    trial = res + rbit;
    mag   = res[ROOT_W-1:0];
    if (mag >= ROOT_W'(PIX_MAX)) begin
      edge_n = '0;
    end else begin
      edge_n = PIX_W'(PIX_MAX) - mag[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.grad) begin
      vx_q <= $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
      vy_q <= $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
    end
    if (cmd.square) begin
      sq_x <= px[SQ_W-1:0];
      sq_y <= py[SQ_W-1:0];
    end
    if (cmd.sum) begin
      rem  <= ROOT_REG_W'(sq_x) + ROOT_REG_W'(sq_y);
      res  <= '0;
      rbit <= ROOT_REG_W'(1) << ROOT_TOP_BIT;
    end else if (cmd.root_step) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + rbit;
      end else begin
        res <= res >> 1;
      end
      rbit <= rbit >> 2;
    end
  end

  // Output register: load a result, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      edge_res  <= edge_n;
      out_col   <= OUT_COL_W'(qc_q);
      out_row   <= OUT_ROW_W'(qr_q);
      frame_end <= fend_q;
    end
  end

  assign status.hit       = hit;
  assign status.root_last = rbit[0];
  assign status.out_free  = !out_valid || out_ready;

endmodule
